// ----- src/tsc_pkg.sv -----
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants for the three-shunt current sense block.
// ----------------------------------------------------------------------------
package tsc_pkg;

   localparam int ADC_BITS   = 12;
   localparam int ANGLE_BITS = 16;
   localparam int PHASES     = 3;

   localparam int GAIN_W    = 16;
   localparam int GAIN_FRAC = 12;
   localparam int CNT_W     = 16;
   localparam int SUM_W     = ADC_BITS + CNT_W;
   localparam int DIFF_W    = ADC_BITS + 1;
   localparam int PROD_W    = DIFF_W + GAIN_W + 1;
   // |offset - raw| * gain < 2^(ADC_BITS+GAIN_W), so the scaled value fits here
   localparam int LANE_CUR_W = ADC_BITS + GAIN_W - GAIN_FRAC + 1;
   localparam int OUT_W      = 18;
   localparam int MRG_W      = (LANE_CUR_W + 2 > OUT_W + 1) ? LANE_CUR_W + 2 : OUT_W + 1;
   localparam int SKIP_W     = 2;
   localparam int STEP_W     = $clog2(ADC_BITS);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [GAIN_W-1:0] GAIN_RESET  = GAIN_W'(4096);
   localparam logic [CNT_W-1:0]  CAL_RESET   = CNT_W'(384);

   // register index, taken from paddr above the byte offset
   localparam logic REG_GAIN = 1'b0;
   localparam logic REG_CAL  = 1'b1;

   localparam logic [SKIP_W-1:0] SKIP_A = 2'd0;
   localparam logic [SKIP_W-1:0] SKIP_B = 2'd1;
   localparam logic [SKIP_W-1:0] SKIP_C = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_LOAD,
      ST_DIV,
      ST_DIV_DONE,
      ST_SCALE
   } state_type;

   typedef struct packed {
      logic acc_en;
      logic div_load;
      logic div_step;
      logic div_done;
      logic mul_en;
   } lane_ctl_type;

endpackage

// ----- src/tsc_if.sv -----
// ----------------------------------------------------------------------------
// tsc_if
// Request and response channel interfaces (valid/ready).
// ----------------------------------------------------------------------------
interface tsc_req_if import tsc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ADC_BITS-1:0]   raw_phase_a;
   logic [ADC_BITS-1:0]   raw_phase_b;
   logic [ADC_BITS-1:0]   raw_phase_c;
   logic [ANGLE_BITS-1:0] electrical_angle;

   modport source (output valid, raw_phase_a, raw_phase_b, raw_phase_c,
                   electrical_angle, input ready);
   modport sink   (input valid, raw_phase_a, raw_phase_b, raw_phase_c,
                   electrical_angle, output ready);
endinterface

interface tsc_rsp_if import tsc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] current_a;
   logic signed [OUT_W-1:0] current_b;
   logic signed [OUT_W-1:0] current_c;
   logic [SKIP_W-1:0]       skipped_phase;

   modport source (output valid, current_a, current_b, current_c, skipped_phase,
                   input ready);
   modport sink   (input valid, current_a, current_b, current_c, skipped_phase,
                   output ready);
endinterface

// ----- src/tsc_lane.sv -----
// ----------------------------------------------------------------------------
// tsc_lane
// One phase: offset accumulation, radix-2 offset divider, gain multiply.
// ----------------------------------------------------------------------------
module tsc_lane import tsc_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  lane_ctl_type                 ctl,
   input  logic [ADC_BITS-1:0]          raw,
   input  logic [CNT_W-1:0]             divisor,
   input  logic [GAIN_W-1:0]            gain,
   output logic signed [LANE_CUR_W-1:0] cur
);

   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [CNT_W-1:0]           rem_ff, rem_in;
   logic [ADC_BITS-1:0]        quo_ff, quo_in;
   logic [ADC_BITS-1:0]        offset_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;

   logic [CNT_W:0]             trial;
   logic [CNT_W:0]             trial_sub;
   logic                       trial_ge;
   logic signed [DIFF_W-1:0]   diff;
   logic signed [GAIN_W:0]     gain_s;
   logic                       neg;
   logic [PROD_W-1:0]          mag;
   logic signed [LANE_CUR_W-1:0] quo_mag;

   assign sum_in = sum_ff + SUM_W'(raw);

   // Long division, one quotient bit per step. The quotient fits ADC_BITS
   // since the sum is below divisor * 2^ADC_BITS, so the remainder starts
   // from the upper sum bits.
   assign trial     = {rem_ff, quo_ff[ADC_BITS-1]};
   assign trial_sub = trial - {1'b0, divisor};
   assign trial_ge  = (trial >= {1'b0, divisor});
   assign rem_in    = trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
   assign quo_in    = {quo_ff[ADC_BITS-2:0], trial_ge};

   assign diff    = $signed({1'b0, offset_ff}) - $signed({1'b0, raw});
   assign gain_s  = $signed({1'b0, gain});
   assign prod_in = diff * gain_s;

   // truncate toward zero
   assign neg     = prod_ff[PROD_W-1];
   assign mag     = neg ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign quo_mag = $signed(LANE_CUR_W'(mag >> GAIN_FRAC));
   assign cur     = neg ? -quo_mag : quo_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctl.acc_en) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.div_load) begin
         rem_ff <= sum_ff[SUM_W-1:ADC_BITS];
         quo_ff <= sum_ff[ADC_BITS-1:0];
      end else if (ctl.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (ctl.div_done) begin
         offset_ff <= quo_ff;
      end
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ----- src/tsc_merge.sv -----
// ----------------------------------------------------------------------------
// tsc_merge
// Sector decode, rebuild of the skipped phase and output saturation.
// ----------------------------------------------------------------------------
module tsc_merge import tsc_pkg::*; (
   input  logic [ANGLE_BITS-1:0]        angle,
   input  logic signed [LANE_CUR_W-1:0] lane_cur [PHASES],
   output logic signed [OUT_W-1:0]      cur_out  [PHASES],
   output logic [SKIP_W-1:0]            skip_out
);

   localparam int SEXT_W = ANGLE_BITS + 3;
   localparam logic [SEXT_W-1:0] TURN      = SEXT_W'(1) << ANGLE_BITS;
   localparam logic [SEXT_W-1:0] FIVE_TURN = SEXT_W'(5) << ANGLE_BITS;
   localparam logic signed [MRG_W-1:0] SAT_HI = MRG_W'((1 << (OUT_W - 1)) - 1);
   localparam logic signed [MRG_W-1:0] SAT_LO = ~SAT_HI;

   logic [SEXT_W-1:0]        angle_ext;
   logic [SEXT_W-1:0]        six_angle;
   logic signed [MRG_W-1:0]  wide [PHASES];

   assign angle_ext = {3'b000, angle};
   assign six_angle = (angle_ext << 2) + (angle_ext << 1);

   always_comb begin
      if ((six_angle < TURN) || (six_angle > FIVE_TURN)) begin
         skip_out = SKIP_A;
      end else if (!angle[ANGLE_BITS-1]) begin
         skip_out = SKIP_B;
      end else begin
         skip_out = SKIP_C;
      end
   end

   always_comb begin
      for (int k = 0; k < PHASES; k++) begin
         wide[k] = MRG_W'(lane_cur[k]);
      end
      case (skip_out)
         SKIP_A:  wide[0] = -(wide[1] + wide[2]);
         SKIP_B:  wide[1] = -(wide[0] + wide[2]);
         default: wide[2] = -(wide[0] + wide[1]);
      endcase
      for (int k = 0; k < PHASES; k++) begin
         if (wide[k] > SAT_HI) begin
            cur_out[k] = OUT_W'(SAT_HI);
         end else if (wide[k] < SAT_LO) begin
            cur_out[k] = OUT_W'(SAT_LO);
         end else begin
            cur_out[k] = wide[k][OUT_W-1:0];
         end
      end
   end

endmodule

// ----- src/three_shunt_current_sense.sv -----
// ----------------------------------------------------------------------------
// three_shunt_current_sense
// Three-shunt phase current reconstruction with startup offset calibration.
// ----------------------------------------------------------------------------
// Calibration requests give no response. The request that reaches the sample
// target starts the offset divide, busy through the load, ADC_BITS radix-2
// steps in each phase lane, and the commit.
// Calibrated: a request passes the multiply register, then the output register,
// which loads once the output is free; a new request waits until it loads.
// Synchronous reset restores register defaults, clears sums and count, and
// returns the block to calibration; no clearing pass.
// ----------------------------------------------------------------------------
module three_shunt_current_sense import tsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tsc_req_if.sink               req_chan,
   tsc_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // ---------------- configuration registers ----------------
   logic [GAIN_W-1:0] gain_ff;
   logic [CNT_W-1:0]  cal_target_ff;
   logic              csr_wr;
   logic              csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   // byte address 4*i, so the index sits above the two offset bits
   assign csr_idx    = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= GAIN_RESET;
         cal_target_ff <= CAL_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_GAIN: gain_ff       <= csr_pwdata[GAIN_W-1:0];
            REG_CAL:  cal_target_ff <= csr_pwdata[CNT_W-1:0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_GAIN: csr_prdata = CSR_DATA_W'(gain_ff);
         REG_CAL:  csr_prdata = CSR_DATA_W'(cal_target_ff);
         default:  csr_prdata = '0;
      endcase
   end

   // ---------------- sequencer ----------------
   state_type         state_ff, state_in;
   logic              calibrated_ff, calibrated_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              req_acc;
   logic              rsp_acc;
   logic              out_load;
   logic [CNT_W:0]    count_next;
   logic [CNT_W:0]    target_eff;
   logic              cal_last;
   lane_ctl_type      lane_ctl;

   assign req_acc = req_chan.valid & req_chan.ready;
   assign rsp_acc = rsp_chan.valid & rsp_chan.ready;

   // a target of zero behaves as one; a target lowered below the count ends
   // calibration on the next request
   assign count_next = {1'b0, count_ff} + 1'b1;
   assign target_eff = (cal_target_ff == '0) ? (CNT_W + 1)'(1) : {1'b0, cal_target_ff};
   assign cal_last   = (count_next >= target_eff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && calibrated_ff) begin
               state_in = ST_SCALE;
            end else if (req_acc && cal_last) begin
               state_in = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (step_ff == STEP_W'(ADC_BITS - 1)) begin
               state_in = ST_DIV_DONE;
            end
         end
         ST_DIV_DONE: state_in = ST_IDLE;
         ST_SCALE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer; ready is high throughout idle, so valid alone
   // marks an accepted request there
   always_comb begin
      req_chan.ready = 1'b0;
      lane_ctl       = '0;
      out_load       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready  = 1'b1;
            lane_ctl.acc_en = req_chan.valid & ~calibrated_ff;
            lane_ctl.mul_en = req_chan.valid & calibrated_ff;
         end
         ST_DIV_LOAD: lane_ctl.div_load = 1'b1;
         ST_DIV:      lane_ctl.div_step = 1'b1;
         ST_DIV_DONE: lane_ctl.div_done = 1'b1;
         ST_SCALE:    out_load = ~rsp_chan.valid | rsp_chan.ready;
         default:     ;
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      step_in       = step_ff;
      calibrated_in = calibrated_ff;
      if (lane_ctl.acc_en) begin
         count_in = count_next[CNT_W-1:0];
      end
      if (lane_ctl.div_load) begin
         step_in = '0;
      end else if (lane_ctl.div_step) begin
         step_in = step_ff + 1'b1;
      end
      if (lane_ctl.div_done) begin
         calibrated_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         calibrated_ff <= 1'b0;
         count_ff      <= '0;
         step_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         calibrated_ff <= calibrated_in;
         count_ff      <= count_in;
         step_ff       <= step_in;
      end
   end

   // ---------------- phase lanes ----------------
   logic [ADC_BITS-1:0]          lane_raw [PHASES];
   logic signed [LANE_CUR_W-1:0] lane_cur [PHASES];

   assign lane_raw[0] = req_chan.raw_phase_a;
   assign lane_raw[1] = req_chan.raw_phase_b;
   assign lane_raw[2] = req_chan.raw_phase_c;

   for (genvar k = 0; k < PHASES; k++) begin : g_lane
      tsc_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl     (lane_ctl),
         .raw     (lane_raw[k]),
         .divisor (count_ff),
         .gain    (gain_ff),
         .cur     (lane_cur[k])
      );
   end

   // angle travels beside the lane products
   logic [ANGLE_BITS-1:0] angle_ff;

   always_ff @(posedge clock) begin
      if (lane_ctl.mul_en) begin
         angle_ff <= req_chan.electrical_angle;
      end
   end

   // ---------------- merge and output register ----------------
   logic signed [OUT_W-1:0] mrg_cur [PHASES];
   logic [SKIP_W-1:0]       mrg_skip;

   tsc_merge u_merge (
      .angle    (angle_ff),
      .lane_cur (lane_cur),
      .cur_out  (mrg_cur),
      .skip_out (mrg_skip)
   );

   logic signed [OUT_W-1:0] out_cur_ff [PHASES];
   logic [SKIP_W-1:0]       out_skip_ff;
   logic                    out_valid_ff, out_valid_in;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_acc) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_cur_ff  <= mrg_cur;
         out_skip_ff <= mrg_skip;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.current_a     = out_cur_ff[0];
   assign rsp_chan.current_b     = out_cur_ff[1];
   assign rsp_chan.current_c     = out_cur_ff[2];
   assign rsp_chan.skipped_phase = out_skip_ff;

endmodule

// ----- tb/sv/phase_current_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_current_checker
// Watches the request, response and register ports of the three-shunt current
// sense block. Tracks calibration and register state, predicts the phase
// currents of every scaled request, and compares them with the responses.
// ----------------------------------------------------------------------------
module phase_current_checker import tsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tsc_req_if                    req_mon,
   tsc_rsp_if                    rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    mismatches,
   output int                    currents_pending,
   output int                    currents_checked
);

   typedef struct packed {
      logic [OUT_W-1:0]  current_a;
      logic [OUT_W-1:0]  current_b;
      logic [OUT_W-1:0]  current_c;
      logic [SKIP_W-1:0] skipped_phase;
   } phase_currents_type;

   localparam longint OUT_HI = (longint'(1) << (OUT_W - 1)) - 1;
   localparam longint OUT_LO = -(longint'(1) << (OUT_W - 1));

   logic [GAIN_W-1:0]   gain;
   logic [CNT_W-1:0]    cal_target;
   logic [SUM_W-1:0]    cal_sums [PHASES];
   logic [CNT_W-1:0]    cal_count;
   logic [ADC_BITS-1:0] zero_offsets [PHASES];
   logic                calibrated;
   phase_currents_type  expected_currents [$];

   function automatic logic [SKIP_W-1:0] skip_for_angle(input logic [ANGLE_BITS-1:0] angle);
      longint turn;
      longint ang;
      turn = longint'(1) << ANGLE_BITS;
      ang  = longint'(angle);
      if (6 * ang < turn || 6 * ang > 5 * turn) return SKIP_A;
      if (2 * ang < turn) return SKIP_B;
      return SKIP_C;
   endfunction

   // (offset - raw) * gain, Q4.12 back to counts, truncated toward zero
   function automatic longint scale_lane(input logic [ADC_BITS-1:0] zero,
                                         input logic [ADC_BITS-1:0] raw,
                                         input logic [GAIN_W-1:0]   g);
      longint prod;
      prod = (longint'(zero) - longint'(raw)) * longint'(g);
      if (prod < 0) return -((-prod) >>> GAIN_FRAC);
      return prod >>> GAIN_FRAC;
   endfunction

   function automatic logic [OUT_W-1:0] clamp_current(input longint v);
      longint s;
      s = v;
      if (s > OUT_HI) s = OUT_HI;
      if (s < OUT_LO) s = OUT_LO;
      return s[OUT_W-1:0];
   endfunction

   function automatic phase_currents_type predict_currents(
                                             input logic [ADC_BITS-1:0]   ra,
                                             input logic [ADC_BITS-1:0]   rb,
                                             input logic [ADC_BITS-1:0]   rc,
                                             input logic [ANGLE_BITS-1:0] angle);
      phase_currents_type r;
      longint ia, ib, ic;
      logic [SKIP_W-1:0] skip;
      skip = skip_for_angle(angle);
      ia = scale_lane(zero_offsets[0], ra, gain);
      ib = scale_lane(zero_offsets[1], rb, gain);
      ic = scale_lane(zero_offsets[2], rc, gain);
      // skipped phase is rebuilt from the two truncated others
      case (skip)
         SKIP_A:  ia = -ib - ic;
         SKIP_B:  ib = -ia - ic;
         default: ic = -ia - ib;
      endcase
      r.current_a     = clamp_current(ia);
      r.current_b     = clamp_current(ib);
      r.current_c     = clamp_current(ic);
      r.skipped_phase = skip;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      phase_currents_type got;
      phase_currents_type want;
      logic [CNT_W-1:0] goal;
      if (reset) begin
         gain       = GAIN_RESET;
         cal_target = CAL_RESET;
         cal_count  = '0;
         calibrated = 1'b0;
         for (int k = 0; k < PHASES; k++) begin
            cal_sums[k]     = '0;
            zero_offsets[k] = '0;
         end
         expected_currents.delete();
         mismatches       = 0;
         currents_checked = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_GAIN) gain = csr_pwdata[GAIN_W-1:0];
            else if (csr_paddr[2] == REG_CAL) cal_target = csr_pwdata[CNT_W-1:0];
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            got.current_a     = rsp_mon.current_a;
            got.current_b     = rsp_mon.current_b;
            got.current_c     = rsp_mon.current_c;
            got.skipped_phase = rsp_mon.skipped_phase;
            if (expected_currents.size() == 0) begin
               mismatches++;
               $display("%0t: response with none expected: a=%0d b=%0d c=%0d skip=%0d",
                        $time, $signed(got.current_a), $signed(got.current_b),
                        $signed(got.current_c), got.skipped_phase);
            end else begin
               want = expected_currents.pop_front();
               currents_checked++;
               if (got.current_a !== want.current_a || got.current_b !== want.current_b ||
                   got.current_c !== want.current_c ||
                   got.skipped_phase !== want.skipped_phase) begin
                  mismatches++;
                  $display("%0t: current mismatch: expected a=%0d b=%0d c=%0d skip=%0d, %s",
                           $time, $signed(want.current_a), $signed(want.current_b),
                           $signed(want.current_c), want.skipped_phase,
                           $sformatf("actual a=%0d b=%0d c=%0d skip=%0d",
                                     $signed(got.current_a), $signed(got.current_b),
                                     $signed(got.current_c), got.skipped_phase));
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            if (!calibrated) begin
               goal = (cal_target == '0) ? CNT_W'(1) : cal_target;
               cal_sums[0] = cal_sums[0] + SUM_W'(req_mon.raw_phase_a);
               cal_sums[1] = cal_sums[1] + SUM_W'(req_mon.raw_phase_b);
               cal_sums[2] = cal_sums[2] + SUM_W'(req_mon.raw_phase_c);
               cal_count   = cal_count + 1'b1;
               // completing request: offsets latched, still no response
               if (cal_count >= goal) begin
                  for (int k = 0; k < PHASES; k++)
                     zero_offsets[k] = ADC_BITS'(cal_sums[k] / cal_count);
                  calibrated = 1'b1;
               end
            end else begin
               expected_currents.push_back(predict_currents(req_mon.raw_phase_a,
                                                            req_mon.raw_phase_b,
                                                            req_mon.raw_phase_c,
                                                            req_mon.electrical_angle));
            end
         end
      end
      currents_pending = expected_currents.size();
   end

endmodule

// ----- tb/sv/tb_three_shunt_current_sense.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_shunt_current_sense
// Drives the three-shunt current sense block through its startup offset
// calibration and then through scaled conversions over a series of gain
// settings, with random idling on both channels and one long output stall.
// A separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_three_shunt_current_sense;
   import tsc_pkg::*;

   localparam int CLK_HALF       = 2;
   localparam int RESET_CYCLES   = 10;
   // offset divide keeps the block busy with nothing to wait on
   localparam int SETTLE_CYCLES  = 24;
   localparam int PHASE_REQUESTS = 110;
   localparam int RANDOM_PHASES  = 7;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 5000;

   localparam logic [ADC_BITS-1:0] ADC_MAX = '1;
   localparam logic [ADC_BITS-1:0] ADC_MID = ADC_BITS'(1 << (ADC_BITS - 1));

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   tsc_req_if req_chan ();
   tsc_rsp_if rsp_chan ();

   int mismatches;
   int currents_pending;
   int currents_checked;
   int requests_sent = 0;
   int gain_writes   = 0;
   int idle_cycles   = 0;

   // idling knobs, flipped by the stimulus process
   bit sender_gaps     = 1'b0;
   bit receiver_stalls = 1'b0;
   bit hold_responses  = 1'b0;

   always #(CLK_HALF) clock = ~clock;

   three_shunt_current_sense uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   phase_current_checker current_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_pready       (csr_pready),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .mismatches       (mismatches),
      .currents_pending (currents_pending),
      .currents_checked (currents_checked)
   );

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // angles right at the sector edges: T/6, T/2 and 5T/6, each from both sides, plus 0 and the top angle
   function automatic logic [ANGLE_BITS-1:0] sector_bound(input int i);
      longint turn;
      turn = longint'(1) << ANGLE_BITS;
      case (i)
         0:       return '0;
         1:       return ANGLE_BITS'(turn / 6);
         2:       return ANGLE_BITS'(turn / 6 + 1);
         3:       return ANGLE_BITS'(turn / 2 - 1);
         4:       return ANGLE_BITS'(turn / 2);
         5:       return ANGLE_BITS'((5 * turn) / 6);
         6:       return ANGLE_BITS'((5 * turn) / 6 + 1);
         default: return '1;
      endcase
   endfunction

   // half near the offset, a quarter rail hits, a quarter full range
   function automatic logic [ADC_BITS-1:0] pick_raw();
      case ($urandom_range(0, 3))
         0:       return ADC_BITS'($urandom());
         1:       return $urandom_range(0, 1) ? ADC_MAX : '0;
         default: return ADC_BITS'($urandom_range(1700, 2400));
      endcase
   endfunction

   function automatic logic [ANGLE_BITS-1:0] pick_angle();
      if ($urandom_range(0, 3) == 0)
         return sector_bound($urandom_range(0, 7)) + ANGLE_BITS'($urandom_range(0, 4))
                - ANGLE_BITS'(2);
      return ANGLE_BITS'($urandom());
   endfunction

   // APB write: setup phase, then access until pready, then back to idle
   task automatic write_register(input logic idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      if (idx == REG_GAIN) gain_writes++;
   endtask

   // Offer one request and hold it until taken. valid stays high into the
   // next request unless a random gap drops it right here.
   task automatic offer(input logic [ADC_BITS-1:0]   ra,
                        input logic [ADC_BITS-1:0]   rb,
                        input logic [ADC_BITS-1:0]   rc,
                        input logic [ANGLE_BITS-1:0] angle);
      req_chan.valid            <= 1'b1;
      req_chan.raw_phase_a      <= ra;
      req_chan.raw_phase_b      <= rb;
      req_chan.raw_phase_c      <= rc;
      req_chan.electrical_angle <= angle;
      do @(posedge clock); while (!req_chan.ready);
      requests_sent++;
      if (sender_gaps && $urandom_range(0, 2) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Close a burst: let every expected response drain, then wait out any
   // divide that a calibration request may have started.
   task automatic finish_burst();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (currents_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [GAIN_W-1:0] gain_for_phase(input int p);
      case (p)
         1:       return GAIN_W'(1);
         3:       return GAIN_W'(1 << (GAIN_W - 1));
         4:       return GAIN_W'($urandom_range(3000, 5200));
         5:       return '1;
         default: return GAIN_W'($urandom());
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Response side: random short stalls, plus the long hold on request
   // ---------------------------------------------------------------------
   initial begin : response_side
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_responses) begin
            // long hold: input side must fill up and back-pressure
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_responses = 1'b0;
            rsp_chan.ready <= 1'b1;
         end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: cycles with no handshake of any kind
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no progress for %0d cycles", $time, idle_cycles);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Main stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      req_chan.valid            <= 1'b0;
      req_chan.raw_phase_a      <= '0;
      req_chan.raw_phase_b      <= '0;
      req_chan.raw_phase_c      <= '0;
      req_chan.electrical_angle <= '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Calibration: start with the largest target, feed six samples, then
      // drop the target to zero (acts as one). The next request completes
      // calibration over all seven samples and gives no response.
      write_register(REG_CAL, CSR_DATA_W'(16'hFFFF));
      offer('0, '0, '0, '0);
      offer(ADC_MAX, ADC_MAX, ADC_MAX, '1);
      repeat (4) offer(ADC_BITS'($urandom_range(1500, 2600)),
                       ADC_BITS'($urandom_range(1500, 2600)),
                       ADC_BITS'($urandom_range(1500, 2600)), pick_angle());
      finish_burst();
      write_register(REG_CAL, '0);
      offer(ADC_MID, ADC_MID, ADC_MID, pick_angle());
      finish_burst();

      // Scaled, reset gain: every sector edge, each phase at both rails
      for (int i = 0; i < 8; i++)
         offer((i & 1) ? ADC_MAX : '0, (i & 2) ? ADC_MAX : '0, (i & 4) ? ADC_MAX : '0,
               sector_bound(i));
      finish_burst();

      // largest gain at the rails
      write_register(REG_GAIN, CSR_DATA_W'(16'hFFFF));
      offer('0, '0, '0, '0);
      offer(ADC_MAX, ADC_MAX, ADC_MAX, ANGLE_BITS'(20000));
      offer('0, ADC_MAX, '0, ANGLE_BITS'(40000));
      offer(ADC_MAX, '0, ADC_MAX, ANGLE_BITS'(60000));
      finish_burst();

      // zero gain: all currents zero
      write_register(REG_GAIN, '0);
      repeat (2) offer(pick_raw(), pick_raw(), pick_raw(), pick_angle());
      finish_burst();

      // Random phases, one gain each. Target rewrites after calibration
      // must change nothing.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_register(REG_GAIN, CSR_DATA_W'(gain_for_phase(p)));
         if (p == 3) write_register(REG_CAL, CSR_DATA_W'(1));
         if (p == 5) write_register(REG_CAL, CSR_DATA_W'($urandom_range(0, 65535)));
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (p == RANDOM_PHASES - 1) begin
               // tail of the run: no idling at all
               sender_gaps     = 1'b0;
               receiver_stalls = 1'b0;
            end else if (n % 25 == 0) begin
               sender_gaps     = $urandom_range(0, 1);
               receiver_stalls = $urandom_range(0, 1);
            end
            if (p == 2 && n == 10) hold_responses = 1'b1;
            offer(pick_raw(), pick_raw(), pick_raw(), pick_angle());
         end
         finish_burst();
      end

      $display("summary: %0d requests sent (7 calibration), %0d phase current responses checked",
               requests_sent, currents_checked);
      $display("summary: %0d gain writes incl. 0, 1 and max, sector edges, one %0d-cycle stall",
               gain_writes, LONG_HOLD);
      if (mismatches == 0 && currents_pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
